// ===== rtl/tpr_pkg.sv =====
// Shared types, sizes and codes of the tile plane pixel renderer.
package tpr_pkg;

	localparam int LINE_WIDTH     = 160;
	localparam int MAP_ROWS       = 32;
	localparam int MAP_COLS       = 32;
	localparam int NUM_CHARACTERS = 256;

	localparam int CELL_DEPTH  = MAP_ROWS * MAP_COLS;
	localparam int PAT_DEPTH   = NUM_CHARACTERS * 16;
	localparam int PLANE_DEPTH = NUM_CHARACTERS * 8;

	localparam int ROW_W   = $clog2(MAP_ROWS);
	localparam int COL_W   = $clog2(MAP_COLS);
	localparam int CELL_AW = $clog2(CELL_DEPTH);
	localparam int CHAR_W  = $clog2(NUM_CHARACTERS);
	localparam int PLANE_AW = $clog2(PLANE_DEPTH);
	localparam int CELL_W  = 14;

	typedef enum logic [1:0] {
		REQ_PATTERN = 2'd0,
		REQ_CELL    = 2'd1,
		REQ_RENDER  = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		CFG_SIZE_MODE    = 3'd0,
		CFG_SCROLL_X     = 3'd1,
		CFG_SCROLL_Y     = 3'd2,
		CFG_OPAQUE_ZERO  = 3'd3,
		CFG_OVERLAY_MARK = 3'd4
	} cfg_index_t;

	// Map cell as stored: priority, flips, palette, character.
	typedef struct packed {
		logic       pri;
		logic       flip_y;
		logic       flip_x;
		logic [2:0] pal;
		logic [7:0] chr;
	} cell_t;

	// Access to the cell store.
	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] waddr;
		cell_t              wdata;
		logic               re;
		logic [CELL_AW-1:0] raddr;
	} cell_req_t;

	// Access to the two bitplane stores.
	typedef struct packed {
		logic                we;
		logic                wplane;
		logic [PLANE_AW-1:0] waddr;
		logic [7:0]          wdata;
		logic                re;
		logic [PLANE_AW-1:0] raddr;
	} pat_req_t;

endpackage

// ===== rtl/tile_plane_pixel_renderer.sv =====
// Top level of the tile plane pixel renderer: a three-stage pixel pipeline.
//
// One transaction per cycle enters on the request channel and render results
// leave on the pixel channel unless stalled; the rate is one item every
// cycle, set by the three-stage pipeline (cell read, pattern read, merge), each
// stage holding one item. Pattern writes (type 0) and cell writes (type 1)
// give no result; type 3 is dropped. A cell write lands in the cell store at
// its accept edge, where renders read the map; a pattern write travels with
// the stream to the second stage, where renders read the patterns, so every
// render sees exactly the writes accepted before it. Pixels at or beyond the
// line width pass the under pixel through. Stores hold nothing defined until
// written and need no clearing. Each stage advances when the one after it is
// empty or advancing, so bubbles close up and a result waiting at the output
// stalls the request channel only once all three stages are full. Write the
// configuration registers only while the pipeline is empty; cfg_ready is
// always high.
module tile_plane_pixel_renderer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [11:0] addr,
	input  logic [7:0]  wdata,
	input  logic [2:0]  cell_palette,
	input  logic        cell_flip_x,
	input  logic        cell_flip_y,
	input  logic        cell_priority,
	input  logic [7:0]  line_y,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  under_pixel,
	// pixel channel
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [7:0]  pixel_out
);

	// configuration registers
	logic       size_mode_q;
	logic [8:0] scroll_x_q;
	logic [8:0] scroll_y_q;
	logic       opaque_zero_q;
	logic       overlay_mark_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_mode_q    <= 1'b0;
			scroll_x_q     <= '0;
			scroll_y_q     <= '0;
			opaque_zero_q  <= 1'b0;
			overlay_mark_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (tpr_pkg::cfg_index_t'(cfg_index))
				tpr_pkg::CFG_SIZE_MODE:    size_mode_q    <= cfg_data[0];
				tpr_pkg::CFG_SCROLL_X:     scroll_x_q     <= cfg_data;
				tpr_pkg::CFG_SCROLL_Y:     scroll_y_q     <= cfg_data;
				tpr_pkg::CFG_OPAQUE_ZERO:  opaque_zero_q  <= cfg_data[0];
				tpr_pkg::CFG_OVERLAY_MARK: overlay_mark_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables: advance into a stage when it is empty or moving on
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic accept;

	assign en3       = !v_s3 || !pix_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_stall = !en1;
	assign accept    = req_valid && en1;

	// stage 0: scroll the position and address the map
	logic [9:0]  py, qx, py_cell, qx_cell;
	logic        is_pat, is_cell, is_rend;
	tpr_pkg::cell_req_t cell_req;
	tpr_pkg::cell_t     cell_rd;

	always_comb begin
		py      = 10'(line_y) + 10'(scroll_y_q);
		qx      = 10'(pixel_x) + 10'(scroll_x_q);
		py_cell = size_mode_q ? (py >> 4) : (py >> 3);
		qx_cell = size_mode_q ? (qx >> 4) : (qx >> 3);
		is_pat  = tpr_pkg::req_type_t'(req_type) == tpr_pkg::REQ_PATTERN;
		is_cell = tpr_pkg::req_type_t'(req_type) == tpr_pkg::REQ_CELL;
		is_rend = tpr_pkg::req_type_t'(req_type) == tpr_pkg::REQ_RENDER;

		cell_req.we          = accept && is_cell
			&& (13'(addr) < 13'(tpr_pkg::CELL_DEPTH));
		cell_req.waddr       = addr[tpr_pkg::CELL_AW-1:0];
		cell_req.wdata.pri    = cell_priority;
		cell_req.wdata.flip_y = cell_flip_y;
		cell_req.wdata.flip_x = cell_flip_x;
		cell_req.wdata.pal    = cell_palette;
		cell_req.wdata.chr    = wdata;
		cell_req.re          = en1;
		cell_req.raddr       = {py_cell[tpr_pkg::ROW_W-1:0], qx_cell[tpr_pkg::COL_W-1:0]};
	end

	tpr_cell_store u_cell_store (
		.clk   (clk),
		.req   (cell_req),
		.rdata (cell_rd)
	);

	// stage 1 registers
	logic        rend_s1;
	logic [11:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic [3:0]  py_s1, qx_s1;
	logic [7:0]  under_s1;
	logic        inl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && (is_pat || is_rend);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			rend_s1  <= is_rend;
			addr_s1  <= addr;
			wdata_s1 <= wdata;
			py_s1    <= py[3:0];
			qx_s1    <= qx[3:0];
			under_s1 <= under_pixel;
			inl_s1   <= 11'(pixel_x) < 11'(tpr_pkg::LINE_WIDTH);
		end
	end

	// stage 1: pick the character and the pattern row; pattern writes land here
	logic [8:0]                  chr_sum;
	logic [8:0]                  chr_off;
	logic [tpr_pkg::CHAR_W-1:0]  chr;
	logic [2:0]                  cy, cx;
	tpr_pkg::pat_req_t           pat_req;
	logic [7:0]                  plane0, plane1;

	always_comb begin
		chr_off = size_mode_q
			? {4'd0, py_s1[3] ^ cell_rd.flip_y, 3'd0, qx_s1[3] ^ cell_rd.flip_x}
			: 9'd0;
		chr_sum = 9'(cell_rd.chr) + chr_off;
		chr     = chr_sum[tpr_pkg::CHAR_W-1:0];
		cy      = cell_rd.flip_y ? ~py_s1[2:0] : py_s1[2:0];
		cx      = cell_rd.flip_x ? ~qx_s1[2:0] : qx_s1[2:0];

		pat_req.we     = v_s1 && !rend_s1 && en2
			&& (13'(addr_s1) < 13'(tpr_pkg::PAT_DEPTH));
		pat_req.wplane = addr_s1[3];
		pat_req.waddr  = {addr_s1[tpr_pkg::CHAR_W+3:4], addr_s1[2:0]};
		pat_req.wdata  = wdata_s1;
		pat_req.re     = en2;
		pat_req.raddr  = {chr, cy};
	end

	tpr_pattern_store u_pattern_store (
		.clk    (clk),
		.req    (pat_req),
		.plane0 (plane0),
		.plane1 (plane1)
	);

	// stage 2 registers
	logic [2:0] cx_s2;
	logic [2:0] pal_s2;
	logic       pri_s2;
	logic [7:0] under_s2;
	logic       inl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && rend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			cx_s2    <= cx;
			pal_s2   <= cell_rd.pal;
			pri_s2   <= cell_rd.pri;
			under_s2 <= under_s1;
			inl_s2   <= inl_s1;
		end
	end

	// stage 2: fetch the colour bits and merge by priority
	logic [2:0] bit_sel;
	logic [1:0] colour;
	logic       take;
	logic [7:0] merged;

	always_comb begin
		bit_sel = ~cx_s2;
		colour  = {plane1[bit_sel], plane0[bit_sel]};
		take    = inl_s2 && (pri_s2 || !under_s2[7])
			&& (colour != 2'd0 || opaque_zero_q);
		merged  = take ? {pri_s2, overlay_mark_q, 1'b0, pal_s2, colour} : under_s2;
	end

	// stage 3: output register
	logic [7:0] pixel_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			pixel_s3 <= merged;
		end
	end

	assign pix_valid = v_s3;
	assign pixel_out = pixel_s3;

endmodule

// ===== rtl/tpr_cell_store.sv =====
// Map cell memory with one write port and one registered read port.
module tpr_cell_store (
	input  logic              clk,
	input  tpr_pkg::cell_req_t req,
	output tpr_pkg::cell_t     rdata
);

	tpr_pkg::cell_t mem [tpr_pkg::CELL_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/tpr_pattern_store.sv =====
// Character pattern memory, split into bitplane 0 and bitplane 1 rows.
module tpr_pattern_store (
	input  logic             clk,
	input  tpr_pkg::pat_req_t req,
	output logic [7:0]       plane0,
	output logic [7:0]       plane1
);

	logic [7:0] mem0 [tpr_pkg::PLANE_DEPTH];
	logic [7:0] mem1 [tpr_pkg::PLANE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we && !req.wplane) begin
			mem0[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			plane0 <= mem0[req.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we && req.wplane) begin
			mem1[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			plane1 <= mem1[req.raddr];
		end
	end

endmodule
